>>> rtl/hfac_pkg.sv
// Package for the height feedback angle-of-attack controller.
// Holds the word types, register indexes, status codes, fixed-point constants,
// the controller state type and the saturation helpers. Depends on nothing.
package hfac_pkg;

    localparam int Q_W        = 32;   // signed Q16.16 word
    localparam int FRAC_W     = 16;
    localparam int SPEED_W    = 31;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int DIVISOR_W  = 31;
    localparam int MUL_W      = 32;
    localparam int ACC_MAG_W  = 47;                 // |accel + g| < 2^47
    localparam int ACC_DIV_W  = ACC_MAG_W + FRAC_W; // 63-bit dividend
    localparam int RATE_MAG_W = 32;                 // |rate| <= 2^31
    localparam int RATE_DIV_W = RATE_MAG_W + FRAC_W;

    localparam int RATE_SCALE = 100;     // 1 / 0.01 s
    localparam int ACC_SCALE  = 10000;   // 1 / (0.01 s)^2
    localparam int GRAV_Q     = 642908;  // 9.81 in Q16.16

    localparam logic signed [Q_W-1:0] GAIN_RESET = 32'sd65536;
    localparam logic signed [Q_W-1:0] BIAS_RESET = 32'sd0;
    localparam logic [DIVISOR_W-1:0]  LIFT_RESET = 31'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_TERM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_SLOPE  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DIV_ERR = 2'd2;

    localparam logic signed [63:0] Q_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN64 = -64'sd2147483648;

    typedef struct packed {
        logic signed [Q_W-1:0]   height;
        logic [SPEED_W-1:0]      speed;
    } in_word_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   aoa_command;
        logic [STATUS_W-1:0]     status;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_START,
        ST_RUN,
        ST_SIGN,
        ST_AOA,
        ST_M3GO,
        ST_M3WAIT,
        ST_SUM,
        ST_CMD
    } ctrl_state_t;

    function automatic logic ovf32(input logic signed [63:0] v);
        ovf32 = (v > Q_MAX64) || (v < Q_MIN64);
    endfunction

    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        if (v > Q_MAX64) begin
            sat32 = Q_MAX64[Q_W-1:0];
        end else if (v < Q_MIN64) begin
            sat32 = Q_MIN64[Q_W-1:0];
        end else begin
            sat32 = v[Q_W-1:0];
        end
    endfunction

endpackage

>>> rtl/hfac_div.sv
// Bit-serial restoring divider: one quotient bit per clock.
// Unsigned dividend of DIVIDEND_W bits over a nonzero DIVISOR_W-bit divisor.
// Depends on hfac_pkg.
module hfac_div #(
    parameter int DIVIDEND_W = hfac_pkg::ACC_DIV_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [DIVIDEND_W-1:0]           dividend,
    input  logic [hfac_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            busy,
    output logic [DIVIDEND_W-1:0]           quotient
);
    import hfac_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W+1:0]  diff;
    logic                  fits;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        fits     = !diff[DIVISOR_W+1];
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/hfac_mul.sv
// Bit-serial signed multiplier: one multiplier bit per clock, shift and add.
// The last (sign) bit subtracts the multiplicand. Depends on hfac_pkg.
module hfac_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [hfac_pkg::MUL_W-1:0]    mcand,
    input  logic signed [hfac_pkg::MUL_W-1:0]    mplier,
    output logic                                 busy,
    output logic signed [2*hfac_pkg::MUL_W-1:0]  product
);
    import hfac_pkg::*;

    localparam int CNT_W = $clog2(MUL_W + 1);
    localparam int EXT_W = MUL_W + 2;

    logic signed [MUL_W:0]   hi_reg, hi_next;
    logic [MUL_W-1:0]        lo_reg, lo_next;
    logic signed [MUL_W-1:0] mcand_reg;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    last_step;
    logic signed [EXT_W-1:0] addend, sum;

    // lo_reg holds the unused multiplier bits and collects product bits from the top.
    always_comb begin
        last_step = (cnt_reg == CNT_W'(1));
        if (lo_reg[0]) begin
            addend = last_step ? -EXT_W'(mcand_reg) : EXT_W'(mcand_reg);
        end else begin
            addend = '0;
        end
        sum       = EXT_W'(hi_reg) + addend;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            hi_next   = '0;
            lo_next   = mplier;
            cnt_next  = CNT_W'(MUL_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum[EXT_W-1:1];
            lo_next  = {sum[0], lo_reg[MUL_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (start) begin
            mcand_reg <= mcand;
        end
    end

    assign busy    = busy_reg;
    assign product = {hi_reg[MUL_W-1:0], lo_reg};

endmodule

>>> rtl/height_feedback_aoa_controller_core.sv
// Top level of the height feedback angle-of-attack controller.
// Instantiates hfac_div and hfac_mul; depends on hfac_pkg.
//
// Each input word carries a Q16.16 height sample and a forward speed. The block keeps the
// two previous heights, forms the vertical rate and acceleration by finite differences over
// a 0.01 s tick, computes the needed angle of attack (accel + 9.81) / lift_slope plus
// rate / speed, and subtracts the feedback g1*h + g2*rate + g3*aoa + g4. The command is
// saturated to 32 bits and status reports 0 for ok, 1 when any stage saturated, and 2 with
// a zero command when speed or lift_slope is zero. The 63-step bit-serial divider for the
// acceleration term is the longest unit, and one 32-step bit-serial multiply for the angle
// gain runs after all units have finished. A zero speed word skips the arithmetic. One word
// is in work at a time, but a finished result waits in the output register, so the next
// word can be accepted while the previous one is unread.
// Configuration writes are taken in any cycle and must only be issued while the block is idle.
module height_feedback_aoa_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hfac_pkg::in_word_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hfac_pkg::out_word_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hfac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hfac_pkg::Q_W-1:0]          cfg_data
);
    import hfac_pkg::*;

    // Widths of the intermediate values, sized to their worst case.
    localparam int D1_W    = Q_W + 1;          // first difference
    localparam int D2_W    = Q_W + 2;          // second difference
    localparam int RATE_XW = D1_W + 7;         // first difference times 100
    localparam int NUM_W   = ACC_MAG_W + 1;    // accel + 9.81, signed
    localparam int T1_MW   = 57;               // clamp magnitude is 2^56
    localparam int T1_W    = T1_MW + 1;
    localparam int T2_W    = RATE_DIV_W + 1;
    localparam int AOA_XW  = T1_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SHP_W   = PROD_W - FRAC_W;  // product shifted down by 16
    localparam int PSUM_W  = SHP_W + 2;
    localparam int P_W     = PSUM_W + 1;
    localparam int CMD_XW  = P_W + 1;
    localparam logic [ACC_DIV_W-1:0] T1_LIM = ACC_DIV_W'(1) << (T1_MW - 1);

    ctrl_state_t state_reg, state_next;

    // Configuration registers.
    logic signed [Q_W-1:0]  height_gain_reg, rate_gain_reg, angle_gain_reg, bias_term_reg;
    logic [DIVISOR_W-1:0]   lift_slope_reg;

    // Height history.
    logic signed [Q_W-1:0]  last_reg, older_reg;

    // Datapath registers for the word in work.
    logic signed [Q_W-1:0]    h_reg;
    logic [SPEED_W-1:0]       v_reg;
    logic                     err_reg;
    logic                     sat_reg;
    logic signed [D1_W-1:0]   d1_reg;
    logic signed [D2_W-1:0]   d2_reg;
    logic signed [Q_W-1:0]    rate_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     n_neg_reg, r_neg_reg;
    logic signed [T1_W-1:0]   t1_reg;
    logic signed [T2_W-1:0]   t2_reg;
    logic signed [PSUM_W-1:0] psum_reg;
    logic signed [Q_W-1:0]    aoa_reg;
    logic signed [P_W-1:0]    p_reg;
    out_word_t                out_reg, out_next;
    logic                     m_valid_reg;

    // Handshake and unit control.
    logic accept, err_now, slot_free, out_load;
    logic div_start, mul_a_start, mul_b_start;
    logic div_acc_busy, div_rate_busy, mul_a_busy, mul_b_busy;

    // Combinational datapath values.
    logic signed [RATE_XW-1:0]  rate_wide;
    logic signed [NUM_W-1:0]    num_next;
    logic [NUM_W-1:0]           num_abs;
    logic [RATE_MAG_W:0]        rate_abs;
    logic [ACC_DIV_W-1:0]       acc_dividend, acc_quot;
    logic [RATE_DIV_W-1:0]      rate_dividend, rate_quot;
    logic [T1_MW-1:0]           t1_mag;
    logic signed [AOA_XW-1:0]   aoa_wide;
    logic signed [CMD_XW-1:0]   cmd_wide;
    logic signed [MUL_W-1:0]    mul_a_mcand, mul_a_mplier;
    logic signed [PROD_W-1:0]   prod_a, prod_b;

    assign accept    = s_valid && s_ready;
    assign err_now   = (s_data.speed == '0) || (lift_slope_reg == '0);
    assign slot_free = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // Next state. The two dividers and the first two multiplies all start together in
    // ST_START; the angle-gain multiply has to wait for the angle of attack itself.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = err_now ? ST_CMD : ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_START;
            ST_START:  state_next = ST_RUN;
            ST_RUN: begin
                if (!(div_acc_busy || div_rate_busy || mul_a_busy || mul_b_busy)) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:   state_next = ST_AOA;
            ST_AOA:    state_next = ST_M3GO;
            ST_M3GO:   state_next = ST_M3WAIT;
            ST_M3WAIT: begin
                if (!mul_a_busy) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:    state_next = ST_CMD;
            ST_CMD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        mul_a_start  = 1'b0;
        mul_b_start  = 1'b0;
        out_load     = 1'b0;
        mul_a_mcand  = height_gain_reg;
        mul_a_mplier = h_reg;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_START: begin
                div_start   = 1'b1;
                mul_a_start = 1'b1;
                mul_b_start = 1'b1;
            end
            ST_M3GO: begin
                mul_a_start  = 1'b1;
                mul_a_mcand  = angle_gain_reg;
                mul_a_mplier = aoa_reg;
            end
            ST_CMD:   out_load = slot_free;
            default:  s_ready = 1'b0;
        endcase
    end

    // Rate is saturated to 32 bits; the acceleration term is kept exact at 48 bits.
    assign rate_wide = RATE_XW'(d1_reg) * RATE_XW'(RATE_SCALE);
    assign num_next  = NUM_W'(d2_reg) * NUM_W'(ACC_SCALE) + NUM_W'(GRAV_Q);

    // The dividers work on magnitudes scaled up by 2^16; the sign is put back afterwards,
    // which gives truncation toward zero.
    assign num_abs       = num_reg[NUM_W-1] ? -num_reg : num_reg;
    assign rate_abs      = rate_reg[Q_W-1] ? -(RATE_MAG_W+1)'(rate_reg)
                                           : (RATE_MAG_W+1)'(rate_reg);
    assign acc_dividend  = {num_abs[ACC_MAG_W-1:0], {FRAC_W{1'b0}}};
    assign rate_dividend = {rate_abs[RATE_MAG_W-1:0], {FRAC_W{1'b0}}};

    // The acceleration quotient is clamped to 2^56 in magnitude before the sum.
    assign t1_mag   = (acc_quot > T1_LIM) ? T1_LIM[T1_MW-1:0] : acc_quot[T1_MW-1:0];
    assign aoa_wide = AOA_XW'(t1_reg) + AOA_XW'(t2_reg);
    assign cmd_wide = CMD_XW'(aoa_reg) - CMD_XW'(p_reg);

    always_comb begin
        out_next = '0;
        if (err_reg) begin
            out_next.aoa_command = '0;
            out_next.status      = STATUS_DIV_ERR;
        end else begin
            out_next.aoa_command = sat32(64'(cmd_wide));
            out_next.status      = (sat_reg || ovf32(64'(cmd_wide))) ? STATUS_SAT : STATUS_OK;
        end
    end

    // Control state, configuration and height history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            height_gain_reg <= GAIN_RESET;
            rate_gain_reg   <= GAIN_RESET;
            angle_gain_reg  <= GAIN_RESET;
            bias_term_reg   <= BIAS_RESET;
            lift_slope_reg  <= LIFT_RESET;
            last_reg        <= '0;
            older_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HEIGHT_GAIN: height_gain_reg <= cfg_data;
                    CFG_RATE_GAIN:   rate_gain_reg   <= cfg_data;
                    CFG_ANGLE_GAIN:  angle_gain_reg  <= cfg_data;
                    CFG_BIAS_TERM:   bias_term_reg   <= cfg_data;
                    CFG_LIFT_SLOPE:  lift_slope_reg  <= cfg_data[DIVISOR_W-1:0];
                    default:         lift_slope_reg  <= lift_slope_reg;
                endcase
            end
            // The history advances on every accepted word, error words included.
            if (accept) begin
                older_reg <= last_reg;
                last_reg  <= s_data.height;
            end
        end
    end

    // Payload registers of the word in work.
    always_ff @(posedge aclk) begin
        if (accept) begin
            h_reg   <= s_data.height;
            v_reg   <= s_data.speed;
            err_reg <= err_now;
            d1_reg  <= D1_W'(s_data.height) - D1_W'(last_reg);
            d2_reg  <= D2_W'(s_data.height) - (D2_W'(last_reg) <<< 1) + D2_W'(older_reg);
        end
        if (state_reg == ST_SCALE) begin
            rate_reg <= sat32(64'(rate_wide));
            sat_reg  <= ovf32(64'(rate_wide));
            num_reg  <= num_next;
        end
        if (state_reg == ST_START) begin
            n_neg_reg <= num_reg[NUM_W-1];
            r_neg_reg <= rate_reg[Q_W-1];
        end
        if (state_reg == ST_SIGN) begin
            t1_reg   <= n_neg_reg ? -$signed({1'b0, t1_mag}) : $signed({1'b0, t1_mag});
            t2_reg   <= r_neg_reg ? -$signed({1'b0, rate_quot}) : $signed({1'b0, rate_quot});
            // Shifting the exact product down by 16 is the floor the feedback calls for.
            psum_reg <= PSUM_W'($signed(prod_a[PROD_W-1:FRAC_W]))
                      + PSUM_W'($signed(prod_b[PROD_W-1:FRAC_W]))
                      + PSUM_W'(bias_term_reg);
        end
        if (state_reg == ST_AOA) begin
            aoa_reg <= sat32(64'(aoa_wide));
            sat_reg <= sat_reg || ovf32(64'(aoa_wide));
        end
        if (state_reg == ST_SUM) begin
            p_reg <= P_W'(psum_reg) + P_W'($signed(prod_a[PROD_W-1:FRAC_W]));
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // (accel + 9.81) / lift_slope
    hfac_div #(
        .DIVIDEND_W (ACC_DIV_W)
    ) u_div_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_dividend),
        .divisor  (lift_slope_reg),
        .busy     (div_acc_busy),
        .quotient (acc_quot)
    );

    // rate / speed
    hfac_div #(
        .DIVIDEND_W (RATE_DIV_W)
    ) u_div_rate (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rate_dividend),
        .divisor  (v_reg),
        .busy     (div_rate_busy),
        .quotient (rate_quot)
    );

    // Height gain times height, then reused for angle gain times angle of attack.
    hfac_mul u_mul_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_a_start),
        .mcand   (mul_a_mcand),
        .mplier  (mul_a_mplier),
        .busy    (mul_a_busy),
        .product (prod_a)
    );

    // Rate gain times rate.
    hfac_mul u_mul_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_b_start),
        .mcand   (rate_gain_reg),
        .mplier  (rate_reg),
        .busy    (mul_b_busy),
        .product (prod_b)
    );

    // Only one word is in work, so acceptance closes the input in the cycle after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a word was still in work");

    // Each accepted word shifts the height history by one place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (last_reg == $past(s_data.height)) && (older_reg == $past(last_reg)))
        else $error("height history did not advance on an accepted word");

    // The sum stage may only read unit results once every serial unit has finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN)
        |-> !(div_acc_busy || div_rate_busy || mul_a_busy || mul_b_busy))
        else $error("serial unit still busy when its result was used");

    // A division error always carries a zero command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STATUS_DIV_ERR)) |-> (m_data.aoa_command == '0))
        else $error("division error word with a nonzero command");

endmodule

>>> tb/tb_height_feedback_aoa_controller_core.sv
// Testbench for height_feedback_aoa_controller_core: drives height/speed words and register
// writes over valid/ready channels and checks every command word against a built-in predictor.
// Depends on hfac_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_height_feedback_aoa_controller_core;
    import hfac_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int ITEMS_PER_PASS = 105;
    localparam int RANDOM_PASSES  = 6;
    localparam int TAIL_CYCLES    = 200;   // wait after the drain for stray words
    localparam int STALL_LIMIT    = 4000;  // cycles without any handshake before giving up

    // The acceleration quotient is clamped to +/- 2^56 before it is added to the rate term.
    localparam longint ACCEL_TERM_CAP = 64'sd1 <<< 56;

    // Tracks the controller: its own copy of the gains and the height history, and a queue
    // of command words still owed by the block, oldest first.
    class aoa_tracker;
        logic signed [Q_W-1:0]  height_gain;
        logic signed [Q_W-1:0]  rate_gain;
        logic signed [Q_W-1:0]  angle_gain;
        logic signed [Q_W-1:0]  bias_term;
        logic [DIVISOR_W-1:0]   lift_slope;
        longint                 last_height;
        longint                 older_height;
        bit                     clipped;
        int                     mismatches;
        out_word_t              pending_commands[$];

        function void restart();
            height_gain  = GAIN_RESET;
            rate_gain    = GAIN_RESET;
            angle_gain   = GAIN_RESET;
            bias_term    = BIAS_RESET;
            lift_slope   = LIFT_RESET;
            last_height  = 0;
            older_height = 0;
            mismatches   = 0;
            pending_commands.delete();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] value);
            case (idx)
                CFG_HEIGHT_GAIN: height_gain = value;
                CFG_RATE_GAIN:   rate_gain   = value;
                CFG_ANGLE_GAIN:  angle_gain  = value;
                CFG_BIAS_TERM:   bias_term   = value;
                CFG_LIFT_SLOPE:  lift_slope  = value[DIVISOR_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > Q_MAX64) begin
                clipped = 1'b1;
                return Q_MAX64;
            end
            if (v < Q_MIN64) begin
                clipped = 1'b1;
                return Q_MIN64;
            end
            return v;
        endfunction

        // Q16.16 quotient, truncated toward zero.
        function longint scaled_quotient(longint num, longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? -num : num;
            q   = (mag << FRAC_W) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        // Q16.16 product, rounded toward minus infinity.
        function longint gain_product(logic signed [Q_W-1:0] g, longint x);
            longint p;
            p = longint'(g) * x;
            return p >>> FRAC_W;
        endfunction

        function out_word_t predict_command(in_word_t w);
            out_word_t r;
            longint    h;
            longint    rate;
            longint    accel;
            longint    t1;
            longint    t2;
            longint    aoa;
            longint    fb;
            h             = longint'(w.height);
            clipped       = 1'b0;
            r.aoa_command = '0;
            r.status      = STATUS_DIV_ERR;
            if (w.speed != '0 && lift_slope != '0) begin
                rate  = clip32((h - last_height) * RATE_SCALE);
                accel = (h - 2 * last_height + older_height) * ACC_SCALE;
                t1    = scaled_quotient(accel + GRAV_Q, lift_slope);
                t2    = scaled_quotient(rate, w.speed);
                if (t1 > ACCEL_TERM_CAP) t1 = ACCEL_TERM_CAP;
                if (t1 < -ACCEL_TERM_CAP) t1 = -ACCEL_TERM_CAP;
                aoa = clip32(t1 + t2);
                fb  = gain_product(height_gain, h) + gain_product(rate_gain, rate)
                    + gain_product(angle_gain, aoa) + longint'(bias_term);
                r.aoa_command = Q_W'(clip32(aoa - fb));
                r.status      = clipped ? STATUS_SAT : STATUS_OK;
            end
            // The new height enters the history even on a division error.
            older_height = last_height;
            last_height  = h;
            return r;
        endfunction

        function void note_sample(in_word_t w);
            pending_commands.push_back(predict_command(w));
        endfunction

        function void check_command(out_word_t got);
            out_word_t want;
            if (pending_commands.size() == 0) begin
                $display("%0t: unexpected word, aoa_command %0d status %0d",
                         $time, got.aoa_command, got.status);
                mismatches++;
                return;
            end
            want = pending_commands.pop_front();
            if (got.aoa_command !== want.aoa_command) begin
                $display("%0t: aoa_command expected %0d got %0d",
                         $time, want.aoa_command, got.aoa_command);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_word_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_word_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [Q_W-1:0]         cfg_data  = '0;

    aoa_tracker             tracker;
    bit                     quiet = 1'b0;      // no idling on either side when set
    logic signed [Q_W-1:0]  trail_height = '0; // last height handed out by the generator
    int                     cycles_since_word = 0;

    height_feedback_aoa_controller_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Every handshake is observed here at the clock edge. The result is checked before the
    // new sample is noted, so a word that shows up with nothing owed is caught as such.
    // The same block runs the watchdog, which only counts cycles with no handshake at all.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_command(m_data);
            if (s_valid && s_ready) tracker.note_sample(s_data);
            if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
                cycles_since_word = 0;
            end else begin
                cycles_since_word++;
            end
            if (cycles_since_word >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL height_feedback_aoa_controller_core");
                $finish;
            end
        end
    end

    // Result side back-pressure: runs of ready broken by stalls of random length. Each pass
    // waits on clock edges between assignments, so m_ready changes at most once per step.
    task automatic drive_result_ready();
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Offers one input word, sometimes after a gap, and returns on the edge it is taken.
    // Valid stays high into the next word when there is no gap.
    task automatic send_sample(input in_word_t w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // The sender holds off until every owed word has come back. The first check follows a clock
    // edge, after the monitor has noted the last accepted sample.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_commands.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Called only with the block idle; writes all five registers back to back.
    task automatic load_settings(input logic [Q_W-1:0] g1, input logic [Q_W-1:0] g2,
                                 input logic [Q_W-1:0] g3, input logic [Q_W-1:0] g4,
                                 input logic [Q_W-1:0] lift);
        write_reg(CFG_HEIGHT_GAIN, g1);
        write_reg(CFG_RATE_GAIN, g2);
        write_reg(CFG_ANGLE_GAIN, g3);
        write_reg(CFG_BIAS_TERM, g4);
        write_reg(CFG_LIFT_SLOPE, lift);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pair(input logic [Q_W-1:0] h, input logic [SPEED_W-1:0] v);
        in_word_t w;
        w.height = h;
        w.speed  = v;
        send_sample(w);
    endtask

    // Gains are mostly moderate so that unsaturated commands come out, with the extremes and
    // full-range patterns mixed in.
    function automatic logic [Q_W-1:0] random_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [Q_W-1:0] random_lift();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0001;
            1:       return 32'h7fff_ffff;
            2:       return $urandom();
            default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
        endcase
    endfunction

    // Most heights follow a smooth trajectory with small steps, as real samples would, so the
    // rate and acceleration stay in range. The rest are jumps, full-range patterns and the
    // extremes. Speed zero turns up now and then for the division error path.
    function automatic in_word_t next_sample();
        in_word_t w;
        case ($urandom_range(0, 9))
            0, 1:    w.height = $urandom();
            2:       w.height = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            3:       w.height = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: w.height = trail_height + ($urandom_range(0, 2048) - 1024);
        endcase
        trail_height = w.height;
        case ($urandom_range(0, 19))
            0:          w.speed = '0;
            1:          w.speed = 31'h7fff_ffff;
            2:          w.speed = 31'd1;
            3, 4, 5:    w.speed = SPEED_W'($urandom());
            default:    w.speed = SPEED_W'($urandom_range(32'h0000_4000, 32'h0040_0000));
        endcase
        return w;
    endfunction

    initial begin
        tracker = new();
        tracker.restart();
        fork
            drive_result_ready();
        join_none
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset gains: ordinary values, extreme heights that saturate the rate, the smallest
        // and largest speeds, and zero speed in the middle of a trajectory so that the
        // history keeps moving through the error.
        send_pair(32'h0001_0000, 31'h0001_0000);
        send_pair(32'h0001_8000, 31'd1);
        send_pair(32'h7fff_ffff, 31'h7fff_ffff);
        send_pair(32'h8000_0000, 31'h7fff_ffff);
        send_pair(32'h8000_0000, 31'd0);
        send_pair(32'h7fff_ffff, 31'd1);
        send_pair(32'h0000_0000, 31'd0);
        send_pair(32'hffff_ffff, 31'h0000_8000);
        send_pair(32'h0000_0100, 31'h0001_0000);
        send_pair(32'h0000_0100, 31'h0001_0000);

        // Largest gains and bias with the smallest lift slope, which makes the acceleration
        // quotient as large as it gets.
        wait_for_results();
        load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
        send_pair(32'h0000_0000, 31'h0001_0000);
        send_pair(32'h7fff_ffff, 31'd1);
        send_pair(32'h8000_0000, 31'h7fff_ffff);

        // Most negative gains and bias with the largest lift slope.
        wait_for_results();
        load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff);
        send_pair(32'h7fff_ffff, 31'h7fff_ffff);
        send_pair(32'h8000_0000, 31'd1);
        send_pair(32'h0000_0000, 31'h0000_4000);

        // A zero lift slope is handled like zero speed.
        wait_for_results();
        load_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
        send_pair(32'h0002_0000, 31'h0001_0000);
        send_pair(32'h8000_0000, 31'h7fff_ffff);

        // Unity gains again; the top bit of the lift slope write lies outside the register.
        wait_for_results();
        load_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
                      32'h8001_0000);
        send_pair(32'h0000_0200, 31'h0002_0000);
        send_pair(32'h0000_0300, 31'h0002_0000);

        // Random passes, each under new settings. Some passes pause halfway until every
        // owed word is back, and the last one runs with no idling at all.
        for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
            wait_for_results();
            load_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                          random_lift());
            quiet = (pass == RANDOM_PASSES - 1);
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                if (n == ITEMS_PER_PASS / 2 && pass % 2 == 0) wait_for_results();
                send_sample(next_sample());
            end
        end

        // Drain, then leave room for any stray word the block might still put out.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_commands.size() == 0) begin
            $display("PASS height_feedback_aoa_controller_core");
        end else begin
            $display("FAIL height_feedback_aoa_controller_core");
        end
        $finish;
    end

endmodule
